// ----- hw/rtl/ils_pkg.sv -----
// ils_pkg: shared constants, request codes and control types for the indexed list store.
// Used by ils_ctrl, ils_datapath and indexed_list_store_unit.
package ils_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned POS_W = 5;
  localparam int unsigned IN_W = 40;
  localparam int unsigned OUT_W = 40;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DROP = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [WORD_W-1:0] NOT_READ = {WORD_W{1'b1}};

  typedef struct packed {
    logic load;
    logic exec;
  } ils_cmd_t;

endpackage

// ----- hw/rtl/ils_ctrl.sv -----
// ils_ctrl: handshake controller for the indexed list store.
// Sequences request capture and execution and owns the result valid flag; uses ils_pkg.
module ils_ctrl
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ils_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;
  assign cmd.load = in_tvalid && in_tready;
  assign cmd.exec = (state_r == S_EXEC) && slot_free;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_load_and_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec)) else $error("load and exec in same cycle");

  a_load_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC)) else $error("load did not enter exec");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid) else $error("exec did not raise result valid");

endmodule

// ----- hw/rtl/ils_datapath.sv -----
// ils_datapath: request register, row of shifting entry cells, fill count and result register.
// Driven by ils_ctrl commands; uses ils_pkg.
module ils_datapath
  import ils_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ils_cmd_t         cmd,
  input  logic [IN_W-1:0]  req_data,
  output logic [OUT_W-1:0] res_data
);

  logic [REQ_W-1:0]  req_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] cells_r [DEPTH];
  logic [WORD_W-1:0] cells_nxt [DEPTH];
  logic [WORD_W-1:0] up_src [DEPTH];
  logic [WORD_W-1:0] dn_src [DEPTH];
  logic [OUT_W-1:0]  res_r, res_nxt;

  logic              ins_ok, rem_ok, drop_ok, read_ok, clr_ok, acc;
  logic [POS_W-1:0]  ins_pos;
  logic [WORD_W-1:0] rd_value;

  assign up_src[0] = val_r;
  assign dn_src[DEPTH-1] = cells_r[DEPTH-1];
  for (genvar g = 1; g < DEPTH; g++) begin : g_up
    assign up_src[g] = cells_r[g-1];
    assign dn_src[g-1] = cells_r[g];
  end

  always_comb begin
    ins_ok = ((req_r == REQ_INSERT) && (pos_r <= cnt_r) && (cnt_r < CNT_FULL)) ||
             ((req_r == REQ_APPEND) && (cnt_r < CNT_FULL));
    ins_pos = (req_r == REQ_APPEND) ? cnt_r : pos_r;
    rem_ok = (req_r == REQ_REMOVE) && (pos_r < cnt_r);
    drop_ok = (req_r == REQ_DROP) && (cnt_r != '0);
    read_ok = (req_r == REQ_READ) && (pos_r < cnt_r);
    clr_ok = (req_r == REQ_CLEAR);
    acc = ins_ok || rem_ok || drop_ok || read_ok || clr_ok;
    rd_value = read_ok ? cells_r[pos_r[IDX_W-1:0]] : NOT_READ;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rem_ok || drop_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (clr_ok) begin
      cnt_nxt = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (ins_ok) begin
        if (CNT_W'(i) == ins_pos) begin
          cells_nxt[i] = val_r;
        end else if ((CNT_W'(i) > ins_pos) && (CNT_W'(i) <= cnt_r)) begin
          cells_nxt[i] = up_src[i];
        end
      end else if (rem_ok) begin
        if ((CNT_W'(i) >= pos_r) && ((CNT_W'(i) + CNT_W'(1)) < cnt_r)) begin
          cells_nxt[i] = dn_src[i];
        end
      end
    end
  end

  assign res_nxt = {(cnt_nxt == '0), cnt_nxt, acc, read_ok, rd_value};
  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_data[REQ_W-1:0];
      pos_r <= req_data[REQ_W +: POS_W];
      val_r <= req_data[REQ_W+POS_W +: WORD_W];
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("fill count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && clr_ok) |=> (cnt_r == '0)) else $error("clear left entries");

  a_res_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (res_r[OUT_W-2 -: CNT_W] == cnt_r)) else $error("result count mismatch");

endmodule

// ----- hw/rtl/indexed_list_store_unit.sv -----
// indexed_list_store_unit: top level of the indexed list store.
// Instantiates ils_ctrl and ils_datapath; uses ils_pkg.
//
// An ordered list of up to 16 signed 32-bit words held in a row of registered cells. Each input
// item is a request (append, drop last, insert at, remove at, read at, clear) and produces exactly
// one result item carrying the read word (-1 when nothing is read), read valid, accepted, the
// entry count after the request and an empty flag. Insert and remove shift all later cells in the
// single execute step. An item is handled by capturing the request into the request register and
// then running it through the cell row into the result register; a new request is taken only
// after the last one has executed. A result waiting at the output stalls the execute step and so
// also the capture of the next request.
module indexed_list_store_unit
  import ils_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [2:0] req_type, [7:3] position, [39:8] value_in
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] read_value, [32] read_valid, [33] accepted, [38:34] entry_count, [39] is_empty
  output logic [OUT_W-1:0] out_tdata
);

  ils_cmd_t cmd;

  ils_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ils_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .req_data (in_tdata),
    .res_data (out_tdata)
  );

endmodule

// ----- dv/indexed_list_store_unit_tb.sv -----
// Testbench for indexed_list_store_unit: stream-driven list requests checked against an
// in-bench list predictor, with random sender gaps and receiver stalls.
// Depends on ils_pkg and the indexed_list_store_unit RTL.
`timescale 1ns / 100ps

module indexed_list_store_unit_tb;
  import ils_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value_in;
    logic [POS_W-1:0]  position;
    logic [REQ_W-1:0]  req_type;
  } list_req_t;

  typedef struct packed {
    logic              is_empty;
    logic [CNT_W-1:0]  entry_count;
    logic              accepted;
    logic              read_valid;
    logic [WORD_W-1:0] read_value;
  } list_resp_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  list_req_t  pending_reqs[$];
  list_resp_t expected_resps[$];

  logic [WORD_W-1:0] model_words[DEPTH];
  int unsigned       model_len = 0;

  int burst_left = 0;
  int gap_left = 0;
  int ready_pct = 100;
  int ready_phase = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int n_read_hits = 0;
  int n_at_full = 0;
  list_resp_t exp_resp;
  list_resp_t got_resp;

  indexed_list_store_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic list_resp_t apply_request(list_req_t rq);
    list_resp_t r;
    int i;
    r = '0;
    r.read_value = NOT_READ;
    case (rq.req_type)
      REQ_APPEND: begin
        if (model_len < DEPTH) begin
          model_words[model_len] = rq.value_in;
          model_len++;
          r.accepted = 1'b1;
        end
      end
      REQ_DROP: begin
        if (model_len > 0) begin
          model_len--;
          r.accepted = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (rq.position <= model_len && model_len < DEPTH) begin
          for (i = model_len; i > rq.position; i--) model_words[i] = model_words[i-1];
          model_words[rq.position] = rq.value_in;
          model_len++;
          r.accepted = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (rq.position < model_len) begin
          for (i = rq.position; i + 1 < model_len; i++) model_words[i] = model_words[i+1];
          model_len--;
          r.accepted = 1'b1;
        end
      end
      REQ_READ: begin
        if (rq.position < model_len) begin
          r.read_value = model_words[rq.position];
          r.read_valid = 1'b1;
          r.accepted = 1'b1;
        end
      end
      REQ_CLEAR: begin
        model_len = 0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(model_len);
    r.is_empty = (model_len == 0);
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] op, int pos, logic [WORD_W-1:0] val);
    list_req_t rq;
    rq.req_type = op;
    rq.position = POS_W'(pos);
    rq.value_in = val;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_resps.size() != 0);
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_resps.push_back(apply_request(list_req_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_tdata <= pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern with changing duty, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_pct <= 100;
      ready_phase <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_phase <= $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 75;
          2: ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
      end else begin
        ready_phase <= ready_phase - 1;
      end
      out_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_resp = list_resp_t'(out_tdata);
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        exp_resp = expected_resps.pop_front();
        mismatches += field_mismatch("read_value", exp_resp.read_value, got_resp.read_value);
        mismatches += field_mismatch("read_valid", exp_resp.read_valid, got_resp.read_valid);
        mismatches += field_mismatch("accepted", exp_resp.accepted, got_resp.accepted);
        mismatches += field_mismatch("entry_count", exp_resp.entry_count,
                                     got_resp.entry_count);
        mismatches += field_mismatch("is_empty", exp_resp.is_empty, got_resp.is_empty);
        n_checked++;
        n_accepted += exp_resp.accepted;
        n_read_hits += exp_resp.read_valid;
        if (exp_resp.entry_count == CNT_FULL) n_at_full++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("indexed_list_store_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [REQ_W-1:0]  op;
    logic [WORD_W-1:0] val;
    int n_gen;
    int seg_len;
    int t_app, t_ins, t_drop, t_rem, t_read;
    int roll;
    int pos;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    queue_req(REQ_DROP, 0, '0);
    queue_req(REQ_READ, 0, '0);
    queue_req(REQ_INSERT, 1, 32'h1234_5678);
    queue_req(REQ_REMOVE, 0, '0);
    // fill to capacity
    for (int k = 0; k < DEPTH; k++) begin
      if (k == 0) queue_req(REQ_INSERT, 0, WORD_MIN);
      else if (k == 1) queue_req(REQ_APPEND, 0, WORD_MAX);
      else if (k == 2) queue_req(REQ_INSERT, 2, '1);
      else if ($urandom_range(0, 1) == 0) queue_req(REQ_INSERT, $urandom_range(0, k), $urandom);
      else queue_req(REQ_APPEND, $urandom_range(0, 31), $urandom);
    end
    // full list corner cases
    queue_req(REQ_APPEND, 0, '0);
    queue_req(REQ_INSERT, 3, '0);
    queue_req(REQ_READ, DEPTH - 1, '0);
    queue_req(REQ_REMOVE, 5, '0);
    queue_req(REQ_W'(REQ_CLEAR + 1), 7, '1);
    queue_req('1, 31, '1);
    queue_req(REQ_CLEAR, 0, '0);
    wait_drained();

    // long receiver hold while the sender keeps offering
    hold_req <= hold_req + 1;
    n_gen = 0;
    while (n_gen < RANDOM_ITEMS) begin
      seg_len = $urandom_range(16, 96);
      case ($urandom_range(0, 2))
        0: begin t_app = 35; t_ins = 60; t_drop = 68; t_rem = 76; t_read = 94; end
        1: begin t_app = 12; t_ins = 24; t_drop = 50; t_rem = 76; t_read = 94; end
        default: begin t_app = 22; t_ins = 44; t_drop = 58; t_rem = 72; t_read = 94; end
      endcase
      for (int k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < t_app) op = REQ_APPEND;
        else if (roll < t_ins) op = REQ_INSERT;
        else if (roll < t_drop) op = REQ_DROP;
        else if (roll < t_rem) op = REQ_REMOVE;
        else if (roll < t_read) op = REQ_READ;
        else if (roll < 97) op = REQ_CLEAR;
        else op = REQ_W'($urandom_range(int'(REQ_CLEAR) + 1, (1 << REQ_W) - 1));
        pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, DEPTH);
        case ($urandom_range(0, 15))
          0: val = WORD_MIN;
          1: val = WORD_MAX;
          2: val = '1;
          3: val = '0;
          default: val = $urandom;
        endcase
        queue_req(op, pos, val);
        n_gen++;
        // pause the sender until the block is drained
        if (n_gen == RANDOM_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_resps.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_resps.size());
    end
    $display("Checked %0d list results: %0d accepted, %0d read hits, %0d with the list full.",
             n_checked, n_accepted, n_read_hits, n_at_full);
    $display("Mismatching fields: %0d", mismatches);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("indexed_list_store_unit test passed");
    end else begin
      $display("indexed_list_store_unit test failed");
    end
    $finish;
  end

endmodule

// ----- indexed_list_store_unit.f -----
hw/rtl/ils_pkg.sv
hw/rtl/ils_ctrl.sv
hw/rtl/ils_datapath.sv
hw/rtl/indexed_list_store_unit.sv
dv/indexed_list_store_unit_tb.sv
